/* src/baro_sensor_compensation_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Shared forms for the concurrent checks on the block's ports.
// ---------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define BSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bsc_pkg.sv */
// ---------------------------------------------------------------------------
// Barometric compensation package
// Beat types, register indexes and output limits.
// ---------------------------------------------------------------------------
package bsc_pkg;

  // Input beat: one raw temperature and one raw pressure reading
  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } bsc_req_t;

  // Result beat
  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [24:0]        press_q8;
    logic               press_valid;
  } bsc_res_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TEMP_CALIB = 2'd0,
    CFG_PRESS_LOW  = 2'd1,
    CFG_PRESS_MID  = 2'd2,
    CFG_PRESS_TOP  = 2'd3
  } bsc_cfg_e;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic signed [20:0] TEMP_MIN_CENTI = -21'sd4000;
  localparam logic signed [20:0] TEMP_MAX_CENTI = 21'sd8500;
  localparam logic [24:0]        PRESS_MAX_Q8   = 25'd28160000;

endpackage

/* src/baro_sensor_compensation.sv */
// ---------------------------------------------------------------------------
// Barometric sensor compensation
// Pipelined fixed-point temperature and pressure compensation with twelve
// calibration words, 64-bit wrapping intermediates and saturated outputs.
// ---------------------------------------------------------------------------
//  channel   | signals                                   | flow
//  ----------+-------------------------------------------+------------------
//  request   | start, busy, req_i                        | start && !busy
//  result    | done_o, res_o                             | one-cycle strobe
//  config    | cfg_valid_i, cfg_ready_o, cfg_index_i,    | valid && ready
//            | cfg_data_i                                |
//
//  One beat enters per clock; done_o strobes once the beat has passed the
//  multiply stages, the 64 one-bit stages of the restoring divider and the
//  post stages. busy stays low, so the rate is one beat a cycle.
//  Reset clears every stage valid bit and the calibration registers.
//  The result side never stalls, so no stage ever holds.
// ---------------------------------------------------------------------------
module baro_sensor_compensation (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bsc_pkg::bsc_req_t    req_i,
  output logic                 done_o,
  output bsc_pkg::bsc_res_t    res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i
);
  import bsc_pkg::*;

  localparam int DIV_STEPS = 64;

  // Low 64 bits of a 64x64 product as partials: {cross, low x low}
  function automatic logic [95:0] pp_f(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    ll = x[31:0] * y[31:0];
    lh = x[31:0] * y[63:32];
    hl = x[63:32] * y[31:0];
    return {lh[31:0] + hl[31:0], ll};
  endfunction

  function automatic logic [63:0] pp_sum_f(input logic [95:0] pp);
    return pp[63:0] + {pp[95:64], 32'b0};
  endfunction

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [47:0] tc_q;
  logic [63:0] pl_q;
  logic [63:0] pm_q;
  logic [15:0] pt_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  // Capture a config beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pl_q <= '0;
      pm_q <= '0;
      pt_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bsc_cfg_e'(cfg_index_i))
        CFG_TEMP_CALIB: tc_q <= cfg_data_i[47:0];
        CFG_PRESS_LOW:  pl_q <= cfg_data_i;
        CFG_PRESS_MID:  pm_q <= cfg_data_i;
        CFG_PRESS_TOP:  pt_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = tc_q[15:0];
  assign t2 = tc_q[31:16];
  assign t3 = tc_q[47:32];
  assign p1 = pl_q[15:0];
  assign p2 = pl_q[31:16];
  assign p3 = pl_q[47:32];
  assign p4 = pl_q[63:48];
  assign p5 = pm_q[15:0];
  assign p6 = pm_q[31:16];
  assign p7 = pm_q[47:32];
  assign p8 = pm_q[63:48];
  assign p9 = pt_q;

  // ------------------------------------------------------------------
  // Stage valid bits
  // ------------------------------------------------------------------
  logic s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic s5_vld_q, s6_vld_q, s7_vld_q, s8_vld_q;
  logic dv_vld_q [0:DIV_STEPS];
  logic r0_vld_q, r1_vld_q, r2_vld_q, r3_vld_q, r4_vld_q, r5_vld_q;
  logic out_vld_q;

  // Advance valid bits every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q    <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      s5_vld_q    <= 1'b0;
      s6_vld_q    <= 1'b0;
      s7_vld_q    <= 1'b0;
      s8_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
      r0_vld_q    <= 1'b0;
      r1_vld_q    <= 1'b0;
      r2_vld_q    <= 1'b0;
      r3_vld_q    <= 1'b0;
      r4_vld_q    <= 1'b0;
      r5_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      s0_vld_q    <= start && !busy;
      s1_vld_q    <= s0_vld_q;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= s4_vld_q;
      s6_vld_q    <= s5_vld_q;
      s7_vld_q    <= s6_vld_q;
      s8_vld_q    <= s7_vld_q;
      dv_vld_q[0] <= s8_vld_q;
      r0_vld_q    <= dv_vld_q[DIV_STEPS];
      r1_vld_q    <= r0_vld_q;
      r2_vld_q    <= r1_vld_q;
      r3_vld_q    <= r2_vld_q;
      r4_vld_q    <= r3_vld_q;
      r5_vld_q    <= r4_vld_q;
      out_vld_q   <= r5_vld_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 0: capture the raw readings
  // ------------------------------------------------------------------
  logic [19:0] s0_adt_q, s0_adp_q;
  always_ff @(posedge clk_i) begin
    s0_adt_q <= req_i.raw_temp;
    s0_adp_q <= req_i.raw_press;
  end

  // ------------------------------------------------------------------
  // Stage 1: temperature differences and their products
  // ------------------------------------------------------------------
  logic signed [17:0] ta;
  logic signed [16:0] td;
  logic signed [33:0] tdd;
  logic signed [33:0] s1_tat2_q;
  logic [32:0]        s1_tdd_q;
  logic [19:0]        s1_adp_q;

  assign ta  = $signed({1'b0, s0_adt_q[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign td  = $signed({1'b0, s0_adt_q[19:4]}) - $signed({1'b0, t1});
  assign tdd = td * td;

  always_ff @(posedge clk_i) begin
    s1_tat2_q <= ta * t2;
    s1_tdd_q  <= tdd[32:0];
    s1_adp_q  <= s0_adp_q;
  end

  // ------------------------------------------------------------------
  // Stage 2: first temperature term and second product
  // ------------------------------------------------------------------
  logic signed [33:0] tat2_sh;
  logic signed [21:0] dd_s;
  logic signed [22:0] s2_ta_q;
  logic signed [37:0] s2_tb_q;
  logic [19:0]        s2_adp_q;

  assign tat2_sh = s1_tat2_q >>> 11;
  assign dd_s    = $signed({1'b0, s1_tdd_q[32:12]});

  always_ff @(posedge clk_i) begin
    s2_ta_q  <= tat2_sh[22:0];
    s2_tb_q  <= dd_s * t3;
    s2_adp_q <= s1_adp_q;
  end

  // ------------------------------------------------------------------
  // Stage 3: fine temperature
  // ------------------------------------------------------------------
  logic signed [37:0] tb_sh;
  logic signed [25:0] ta_x, tb_x;
  logic signed [25:0] s3_fine_q;
  logic [19:0]        s3_adp_q;

  assign tb_sh = s2_tb_q >>> 14;
  assign ta_x  = s2_ta_q;
  assign tb_x  = tb_sh[25:0];

  always_ff @(posedge clk_i) begin
    s3_fine_q <= ta_x + tb_x;
    s3_adp_q  <= s2_adp_q;
  end

  // ------------------------------------------------------------------
  // Stage 4: temperature result and pressure offset products
  // ------------------------------------------------------------------
  logic signed [28:0] fine_x, t5;
  logic signed [20:0] tsh;
  logic signed [14:0] temp_sat;
  logic signed [25:0] pa;
  logic signed [51:0] s4_aa_q;
  logic signed [41:0] s4_a5_q, s4_a2_q;
  logic signed [14:0] s4_temp_q;
  logic [19:0]        s4_adp_q;

  assign fine_x = s3_fine_q;
  assign t5     = (fine_x <<< 2) + fine_x + 29'sd128;
  assign tsh    = t5[28:8];
  assign pa     = s3_fine_q - 26'sd128000;

  // Clamp temperature to its range
  always_comb begin
    if (tsh < TEMP_MIN_CENTI) begin
      temp_sat = TEMP_MIN_CENTI[14:0];
    end else if (tsh > TEMP_MAX_CENTI) begin
      temp_sat = TEMP_MAX_CENTI[14:0];
    end else begin
      temp_sat = tsh[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s4_aa_q   <= pa * pa;
    s4_a5_q   <= pa * p5;
    s4_a2_q   <= pa * p2;
    s4_temp_q <= temp_sat;
    s4_adp_q  <= s3_adp_q;
  end

  // ------------------------------------------------------------------
  // Stage 5: square term times P6 and P3
  // ------------------------------------------------------------------
  logic signed [67:0] aap6, aap3;
  logic [63:0]        s5_aap6_q, s5_aap3_q;
  logic signed [41:0] s5_a5_q, s5_a2_q;
  logic signed [14:0] s5_temp_q;
  logic [19:0]        s5_adp_q;

  assign aap6 = s4_aa_q * p6;
  assign aap3 = s4_aa_q * p3;

  always_ff @(posedge clk_i) begin
    s5_aap6_q <= aap6[63:0];
    s5_aap3_q <= aap3[63:0];
    s5_a5_q   <= s4_a5_q;
    s5_a2_q   <= s4_a2_q;
    s5_temp_q <= s4_temp_q;
    s5_adp_q  <= s4_adp_q;
  end

  // ------------------------------------------------------------------
  // Stage 6: offset sum and scale sum, wrapping at 64 bits
  // ------------------------------------------------------------------
  logic signed [63:0] a5x, a2x, p4x, aap3_s;
  logic [63:0]        s6_b_q, s6_a1x_q;
  logic signed [14:0] s6_temp_q;
  logic [19:0]        s6_adp_q;

  assign a5x    = s5_a5_q;
  assign a2x    = s5_a2_q;
  assign p4x    = p4;
  assign aap3_s = s5_aap3_q;

  always_ff @(posedge clk_i) begin
    s6_b_q    <= s5_aap6_q + 64'(a5x <<< 17) + 64'(p4x <<< 35);
    s6_a1x_q  <= 64'(aap3_s >>> 8) + 64'(a2x <<< 12) + 64'h0000_8000_0000_0000;
    s6_temp_q <= s5_temp_q;
    s6_adp_q  <= s5_adp_q;
  end

  // ------------------------------------------------------------------
  // Stage 7: scale times P1, numerator before scaling
  // ------------------------------------------------------------------
  logic [20:0]        pn;
  logic [95:0]        s7_pp1_q;
  logic [63:0]        s7_nb_q;
  logic signed [14:0] s7_temp_q;

  assign pn = 21'd1048576 - {1'b0, s6_adp_q};

  always_ff @(posedge clk_i) begin
    s7_pp1_q  <= pp_f(s6_a1x_q, {48'b0, p1});
    s7_nb_q   <= {12'b0, pn, 31'b0} - s6_b_q;
    s7_temp_q <= s6_temp_q;
  end

  // ------------------------------------------------------------------
  // Stage 8: divisor, numerator times 3125
  // ------------------------------------------------------------------
  logic [63:0]        scale;
  logic signed [30:0] s8_den_q;
  logic [95:0]        s8_ppn_q;
  logic signed [14:0] s8_temp_q;

  assign scale = pp_sum_f(s7_pp1_q);

  always_ff @(posedge clk_i) begin
    s8_den_q  <= scale[63:33];
    s8_ppn_q  <= pp_f(s7_nb_q, 64'd3125);
    s8_temp_q <= s7_temp_q;
  end

  // ------------------------------------------------------------------
  // Divider: sign split, then one quotient bit per stage
  // ------------------------------------------------------------------
  logic [63:0]        num;
  logic [63:0]        num_abs;
  logic [30:0]        den_abs;

  logic [30:0]        dv_rem_q  [0:DIV_STEPS];
  logic [63:0]        dv_nq_q   [0:DIV_STEPS];
  logic [30:0]        dv_den_q  [0:DIV_STEPS];
  logic               dv_neg_q  [0:DIV_STEPS];
  logic               dv_ok_q   [0:DIV_STEPS];
  logic signed [14:0] dv_temp_q [0:DIV_STEPS];

  assign num     = pp_sum_f(s8_ppn_q);
  assign num_abs = num[63] ? (~num + 64'd1) : num;
  assign den_abs = s8_den_q[30] ? (~s8_den_q + 31'd1) : s8_den_q;

  always_ff @(posedge clk_i) begin
    dv_rem_q[0]  <= '0;
    dv_nq_q[0]   <= num_abs;
    dv_den_q[0]  <= den_abs;
    dv_neg_q[0]  <= num[63] ^ s8_den_q[30];
    dv_ok_q[0]   <= (s8_den_q != '0);
    dv_temp_q[0] <= s8_temp_q;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [31:0] sh;
    logic [31:0] diff;
    logic        ge;

    // Shift in the next dividend bit and try a subtract
    assign sh   = {dv_rem_q[k], dv_nq_q[k][63]};
    assign diff = sh - {1'b0, dv_den_q[k]};
    assign ge   = (sh >= {1'b0, dv_den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rem_q[k+1]  <= ge ? diff[30:0] : sh[30:0];
      dv_nq_q[k+1]   <= {dv_nq_q[k][62:0], ge};
      dv_den_q[k+1]  <= dv_den_q[k];
      dv_neg_q[k+1]  <= dv_neg_q[k];
      dv_ok_q[k+1]   <= dv_ok_q[k];
      dv_temp_q[k+1] <= dv_temp_q[k];
    end
  end

  // ------------------------------------------------------------------
  // Post stage 0: signed quotient
  // ------------------------------------------------------------------
  logic [63:0]        qm;
  logic [63:0]        r0_p_q;
  logic               r0_ok_q;
  logic signed [14:0] r0_temp_q;

  assign qm = dv_nq_q[DIV_STEPS];

  always_ff @(posedge clk_i) begin
    r0_p_q    <= dv_neg_q[DIV_STEPS] ? (~qm + 64'd1) : qm;
    r0_ok_q   <= dv_ok_q[DIV_STEPS];
    r0_temp_q <= dv_temp_q[DIV_STEPS];
  end

  // ------------------------------------------------------------------
  // Post stage 1: P9 times shifted quotient, P8 times quotient
  // ------------------------------------------------------------------
  logic signed [63:0] p_s, d13;
  logic signed [63:0] p9x, p8x, p7x;
  logic [95:0]        r1_pp9_q, r1_pp8_q;
  logic [63:0]        r1_p_q, r1_d_q;
  logic               r1_ok_q;
  logic signed [14:0] r1_temp_q;

  assign p_s = r0_p_q;
  assign d13 = p_s >>> 13;
  assign p9x = p9;
  assign p8x = p8;
  assign p7x = p7;

  always_ff @(posedge clk_i) begin
    r1_pp9_q  <= pp_f(p9x, d13);
    r1_pp8_q  <= pp_f(p8x, r0_p_q);
    r1_p_q    <= r0_p_q;
    r1_d_q    <= d13;
    r1_ok_q   <= r0_ok_q;
    r1_temp_q <= r0_temp_q;
  end

  // ------------------------------------------------------------------
  // Post stage 2: resolve partials
  // ------------------------------------------------------------------
  logic [63:0]        r2_x9_q, r2_y8_q, r2_p_q, r2_d_q;
  logic               r2_ok_q;
  logic signed [14:0] r2_temp_q;

  always_ff @(posedge clk_i) begin
    r2_x9_q   <= pp_sum_f(r1_pp9_q);
    r2_y8_q   <= pp_sum_f(r1_pp8_q);
    r2_p_q    <= r1_p_q;
    r2_d_q    <= r1_d_q;
    r2_ok_q   <= r1_ok_q;
    r2_temp_q <= r1_temp_q;
  end

  // ------------------------------------------------------------------
  // Post stage 3: (P9 * d) times d
  // ------------------------------------------------------------------
  logic [95:0]        r3_ppb_q;
  logic [63:0]        r3_y8_q, r3_p_q;
  logic               r3_ok_q;
  logic signed [14:0] r3_temp_q;

  always_ff @(posedge clk_i) begin
    r3_ppb_q  <= pp_f(r2_x9_q, r2_d_q);
    r3_y8_q   <= r2_y8_q;
    r3_p_q    <= r2_p_q;
    r3_ok_q   <= r2_ok_q;
    r3_temp_q <= r2_temp_q;
  end

  // ------------------------------------------------------------------
  // Post stage 4: resolve the square term
  // ------------------------------------------------------------------
  logic [63:0]        r4_bs_q, r4_y8_q, r4_p_q;
  logic               r4_ok_q;
  logic signed [14:0] r4_temp_q;

  always_ff @(posedge clk_i) begin
    r4_bs_q   <= pp_sum_f(r3_ppb_q);
    r4_y8_q   <= r3_y8_q;
    r4_p_q    <= r3_p_q;
    r4_ok_q   <= r3_ok_q;
    r4_temp_q <= r3_temp_q;
  end

  // ------------------------------------------------------------------
  // Post stage 5: sum quotient and both correction terms
  // ------------------------------------------------------------------
  logic signed [63:0] bs_s, y8_s;
  logic [63:0]        r5_s_q;
  logic               r5_ok_q;
  logic signed [14:0] r5_temp_q;

  assign bs_s = r4_bs_q;
  assign y8_s = r4_y8_q;

  always_ff @(posedge clk_i) begin
    r5_s_q    <= r4_p_q + 64'(bs_s >>> 25) + 64'(y8_s >>> 19);
    r5_ok_q   <= r4_ok_q;
    r5_temp_q <= r4_temp_q;
  end

  // ------------------------------------------------------------------
  // Output stage: add P7 offset, clamp, drop on zero divisor
  // ------------------------------------------------------------------
  logic signed [63:0] s_s, pr;
  logic [24:0]        press_sat;
  bsc_res_t           out_q;

  assign s_s = r5_s_q;
  assign pr  = (s_s >>> 8) + (p7x <<< 4);

  always_comb begin
    if (!r5_ok_q || pr < 64'sd0) begin
      press_sat = '0;
    end else if (pr > $signed({39'b0, PRESS_MAX_Q8})) begin
      press_sat = PRESS_MAX_Q8;
    end else begin
      press_sat = pr[24:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.temp_centi  <= r5_temp_q;
    out_q.press_q8    <= press_sat;
    out_q.press_valid <= r5_ok_q;
  end

  assign done_o = out_vld_q;
  assign res_o  = out_q;

endmodule

/* src/bsc_checker.sv */
// ---------------------------------------------------------------------------
// Barometric compensation port checker
// Checks result ranges and the request flow seen at the top-level ports.
// ---------------------------------------------------------------------------
`include "baro_sensor_compensation_defines.svh"

module bsc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input bsc_pkg::bsc_res_t    res_o
);
  import bsc_pkg::*;

  // Temperature beat stays inside its clamp
  `BSC_ASSERT_IMP(a_temp_range, clk_i, rst_ni, done_o,
    ($signed(res_o.temp_centi) >= -15'sd4000) && ($signed(res_o.temp_centi) <= 15'sd8500),
    "temperature outside clamp")

  // Pressure beat stays inside its clamp
  `BSC_ASSERT_IMP(a_press_range, clk_i, rst_ni, done_o,
    res_o.press_q8 <= PRESS_MAX_Q8, "pressure outside clamp")

  // Dropped pressure reads as zero
  `BSC_ASSERT_IMP(a_press_drop, clk_i, rst_ni, done_o && !res_o.press_valid,
    res_o.press_q8 == '0, "invalid pressure not zero")

  // Accepting a beat never holds off the next one
  `BSC_ASSERT_NXT(a_no_hold, clk_i, rst_ni, start && !busy, !busy,
    "busy raised after accepted beat")

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);
